// ----- src/clt_pkg.sv -----
// Shared types and constants for the caching lock table.
// No dependencies; used by every module of the block.
package clt_pkg;

   localparam int LOCK_BITS = 64;
   localparam int ID_BITS   = 8;

   typedef enum logic [1:0] {
      KIND_OK        = 2'd0,
      KIND_RETRY     = 2'd1,
      KIND_REVOKE    = 2'd2,
      KIND_RETRY_MSG = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ERR_NONE    = 2'd0,
      ERR_TABLE   = 2'd1,
      ERR_QUEUE   = 2'd2,
      ERR_UNKNOWN = 2'd3
   } err_type;

   localparam logic MODE_ACQUIRE = 1'b0;
   localparam logic MODE_RELEASE = 1'b1;

   typedef struct packed {
      logic                 mode;
      logic [LOCK_BITS-1:0] lock_id;
      logic [ID_BITS-1:0]   client_id;
   } req_type;

   typedef struct packed {
      kind_type             kind;
      logic [ID_BITS-1:0]   target_client;
      logic [LOCK_BITS-1:0] target_lock;
      err_type              error;
      logic                 last;
   } rsp_type;

endpackage

// ----- src/caching_lock_table_fifo.sv -----
// Top level of the caching lock table: front search, one-entry job queue, back engine.
// Depends on clt_pkg, clt_front and clt_back.
//
//  channel | ports                         | handshake
//  req     | start, busy, req_data         | taken when start=1 and busy=0
//  rsp     | rsp_strobe, rsp_data          | one-cycle strobe per item, never stalled
//
// The front searches the table in the cycle after acceptance; the back engine
// takes the item at the next edge if idle, reads the waiter memory in ST_READ,
// registers the first result out of ST_READ, then emits any remaining results
// from ST_MSG and ST_REPLY, in that order.
// Busy stays high from acceptance until the back engine takes the item.
// Reset clears entry valid bits, queue heads and counts at once; no sweep.
// The receiver cannot stall, so results are never held back.
module caching_lock_table_fifo #(
   parameter int LOCK_ENTRIES = 16,
   parameter int QUEUE_DEPTH  = 8,
   parameter int CLIENT_BITS  = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  clt_pkg::req_type  req_data,
   output logic              rsp_strobe,
   output clt_pkg::rsp_type  rsp_data
);
   localparam int EW = (LOCK_ENTRIES > 1) ? $clog2(LOCK_ENTRIES) : 1;

   logic [LOCK_ENTRIES-1:0]       valid_vec;
   logic [clt_pkg::LOCK_BITS-1:0] key_vec [LOCK_ENTRIES];
   logic             job_valid, job_take, job_hit, job_free_ok;
   clt_pkg::req_type job_req;
   logic [EW-1:0]    job_entry, job_free;

   // Hold the accepted item in the front until the back engine takes it, so
   // the search sees the table as the previous item left it.
   clt_front #(.LOCK_ENTRIES(LOCK_ENTRIES), .CLIENT_BITS(CLIENT_BITS)) u_front (
      .clock, .reset, .req_start(start), .req_busy(busy), .req_data,
      .valid_vec, .key_vec, .job_valid, .job_take, .job_req, .job_hit,
      .job_entry, .job_free_ok, .job_free
   );

   // Apply the table update at take, then emit messages and the reply in order.
   clt_back #(.LOCK_ENTRIES(LOCK_ENTRIES), .QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
      .clock, .reset, .job_valid, .job_take, .job_req, .job_hit, .job_entry,
      .job_free_ok, .job_free, .valid_vec, .key_vec,
      .rsp_strobe, .rsp_data
   );
endmodule

// ----- src/clt_front.sv -----
// Front end: registers the request, then searches the key table in one pass.
// Depends on clt_pkg; feeds clt_back through a one-entry queue.
module clt_front #(
   parameter int LOCK_ENTRIES = 16,
   parameter int CLIENT_BITS  = 8,
   localparam int EW = (LOCK_ENTRIES > 1) ? $clog2(LOCK_ENTRIES) : 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_start,
   output logic                          req_busy,
   input  clt_pkg::req_type              req_data,
   input  logic [LOCK_ENTRIES-1:0]       valid_vec,
   input  logic [clt_pkg::LOCK_BITS-1:0] key_vec [LOCK_ENTRIES],
   output logic                          job_valid,
   input  logic                          job_take,
   output clt_pkg::req_type              job_req,
   output logic                          job_hit,
   output logic [EW-1:0]                 job_entry,
   output logic                          job_free_ok,
   output logic [EW-1:0]                 job_free
);
   localparam logic [clt_pkg::ID_BITS-1:0] CLIENT_MASK =
      clt_pkg::ID_BITS'((64'd1 << CLIENT_BITS) - 64'd1);

   logic             held_ff, held_in;
   logic             req_take;
   clt_pkg::req_type req_ff, req_in;
   logic             hit_c, free_c;
   logic [EW-1:0]    hit_idx, free_idx;

   // Lowest matching entry and lowest free entry (priority search).
   always_comb begin
      hit_c = 1'b0;
      free_c = 1'b0;
      hit_idx = '0;
      free_idx = '0;
      for (int i = LOCK_ENTRIES - 1; i >= 0; i--) begin
         if (valid_vec[i] && key_vec[i] == req_ff.lock_id) begin
            hit_c = 1'b1;
            hit_idx = EW'(i);
         end
         if (!valid_vec[i]) begin
            free_c = 1'b1;
            free_idx = EW'(i);
         end
      end
   end

   // Keep only the client bits in use.
   always_comb begin
      req_in = req_data;
      req_in.client_id = req_data.client_id & CLIENT_MASK;
   end

   assign req_take = req_start && !req_busy;
   assign held_in  = req_take ? 1'b1 : (job_take ? 1'b0 : held_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= 1'b0;
      end else begin
         held_ff <= held_in;
      end
      if (req_take) begin
         req_ff <= req_in;
      end
   end

   assign req_busy    = held_ff;
   assign job_valid   = held_ff;
   assign job_req     = req_ff;
   assign job_hit     = hit_c;
   assign job_entry   = hit_idx;
   assign job_free_ok = free_c;
   assign job_free    = free_idx;
endmodule

// ----- src/clt_back.sv -----
// Back end: owns the lock table and waiter memory, emits up to three results.
// Depends on clt_pkg; takes classified jobs from clt_front.
module clt_back #(
   parameter int LOCK_ENTRIES = 16,
   parameter int QUEUE_DEPTH  = 8,
   localparam int EW = (LOCK_ENTRIES > 1) ? $clog2(LOCK_ENTRIES) : 1,
   localparam int QW = $clog2(QUEUE_DEPTH),
   localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          job_valid,
   output logic                          job_take,
   input  clt_pkg::req_type              job_req,
   input  logic                          job_hit,
   input  logic [EW-1:0]                 job_entry,
   input  logic                          job_free_ok,
   input  logic [EW-1:0]                 job_free,
   output logic [LOCK_ENTRIES-1:0]       valid_vec,
   output logic [clt_pkg::LOCK_BITS-1:0] key_vec [LOCK_ENTRIES],
   output logic                          rsp_strobe,
   output clt_pkg::rsp_type              rsp_data
);
   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_READ  = 4'b0010,
      ST_MSG   = 4'b0100,
      ST_REPLY = 4'b1000
   } state_type;

   localparam int MW = EW + QW;
   localparam int MEM_DEPTH = 1 << MW;

   state_type state_ff, state_in;
   logic [LOCK_ENTRIES-1:0]       valid_ff;
   logic [clt_pkg::LOCK_BITS-1:0] key_ff [LOCK_ENTRIES];
   logic [QW-1:0]                 head_ff  [LOCK_ENTRIES];
   logic [CW-1:0]                 count_ff [LOCK_ENTRIES];
   logic [clt_pkg::ID_BITS-1:0]   mem [MEM_DEPTH];
   logic [clt_pkg::ID_BITS-1:0]   rd_ff;

   clt_pkg::rsp_type  reply_ff, reply_in;       // final reply of the item
   logic [1:0]        msg_cnt_ff, msg_cnt_in;   // messages ahead of the reply
   clt_pkg::kind_type msg_kind_ff, msg_kind_in; // kind of the first message
   clt_pkg::rsp_type  msg_rsp;
   clt_pkg::rsp_type  out_ff;
   logic              out_strobe_ff;

   logic            wr_en;
   logic [MW-1:0]   wr_addr, rd_addr;
   logic [QW-1:0]   cur_head, next_head, tail;
   logic [QW:0]     tail_sum;
   logic [CW-1:0]   cur_count;

   assign cur_head  = head_ff[job_entry];
   assign cur_count = count_ff[job_entry];
   assign next_head = (cur_head == QW'(QUEUE_DEPTH - 1)) ? '0 : QW'(cur_head + 1'b1);
   assign tail_sum  = {1'b0, cur_head} + (QW+1)'(cur_count);
   assign tail      = (tail_sum >= (QW+1)'(QUEUE_DEPTH)) ?
                      QW'(tail_sum - (QW+1)'(QUEUE_DEPTH)) : QW'(tail_sum);
   assign job_take  = (state_ff == ST_IDLE) && job_valid;
   assign valid_vec = valid_ff;
   assign key_vec   = key_ff;

   // Waiter memory: one write port, one registered read port.
   always_comb begin
      wr_en = 1'b0;
      wr_addr = {job_free, {QW{1'b0}}};
      rd_addr = {job_entry, cur_head};
      if (job_take && job_req.mode == clt_pkg::MODE_ACQUIRE) begin
         if (!job_hit) begin
            wr_en = job_free_ok;
         end else begin
            wr_en = (cur_count < CW'(QUEUE_DEPTH));
            wr_addr = {job_entry, tail};
         end
      end else if (job_take) begin
         rd_addr = {job_entry, next_head};
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= job_req.client_id;
      if (job_take) rd_ff <= mem[rd_addr];
   end

   // Classify the job: reply fields and the messages owed before it.
   always_comb begin
      reply_in.kind = clt_pkg::KIND_RETRY;
      reply_in.target_client = job_req.client_id;
      reply_in.target_lock = job_req.lock_id;
      reply_in.error = clt_pkg::ERR_NONE;
      reply_in.last = 1'b1;
      msg_cnt_in = 2'd0;
      msg_kind_in = clt_pkg::KIND_REVOKE;
      if (job_req.mode == clt_pkg::MODE_ACQUIRE) begin
         if (!job_hit) begin
            if (job_free_ok) begin
               reply_in.kind = clt_pkg::KIND_OK;
            end else begin
               reply_in.error = clt_pkg::ERR_TABLE;
            end
         end else if (cur_count >= CW'(QUEUE_DEPTH)) begin
            reply_in.error = clt_pkg::ERR_QUEUE;
         end else if (cur_count == CW'(1)) begin
            msg_cnt_in = 2'd1;
         end
      end else begin
         reply_in.kind = clt_pkg::KIND_OK;
         if (!job_hit) begin
            reply_in.error = clt_pkg::ERR_UNKNOWN;
         end else if (cur_count > CW'(2)) begin
            msg_cnt_in = 2'd2;
            msg_kind_in = clt_pkg::KIND_RETRY_MSG;
         end else if (cur_count == CW'(2)) begin
            msg_cnt_in = 2'd1;
            msg_kind_in = clt_pkg::KIND_RETRY_MSG;
         end
      end
   end

   // Message to the head client; the second message is always a revoke.
   always_comb begin
      msg_rsp = reply_ff;
      msg_rsp.kind = (state_ff == ST_MSG) ? clt_pkg::KIND_REVOKE : msg_kind_ff;
      msg_rsp.target_client = rd_ff;
      msg_rsp.error = clt_pkg::ERR_NONE;
      msg_rsp.last = 1'b0;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (job_take) state_in = ST_READ;
         end
         ST_READ: begin
            if (msg_cnt_ff == 2'd0) state_in = ST_IDLE;
            else if (msg_cnt_ff == 2'd2) state_in = ST_MSG;
            else state_in = ST_REPLY;
         end
         ST_MSG:   state_in = ST_REPLY;
         ST_REPLY: state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= '0;
         out_strobe_ff <= 1'b0;
         for (int i = 0; i < LOCK_ENTRIES; i++) begin
            head_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         out_strobe_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (job_take) begin
                  reply_ff <= reply_in;
                  msg_cnt_ff <= msg_cnt_in;
                  msg_kind_ff <= msg_kind_in;
                  if (job_req.mode == clt_pkg::MODE_ACQUIRE) begin
                     if (!job_hit) begin
                        if (job_free_ok) begin
                           valid_ff[job_free] <= 1'b1;
                           key_ff[job_free]   <= job_req.lock_id;
                           head_ff[job_free]  <= '0;
                           count_ff[job_free] <= CW'(1);
                        end
                     end else if (cur_count < CW'(QUEUE_DEPTH)) begin
                        count_ff[job_entry] <= CW'(cur_count + 1'b1);
                     end
                  end else if (job_hit) begin
                     count_ff[job_entry] <= CW'(cur_count - 1'b1);
                     if (cur_count == CW'(1)) begin
                        valid_ff[job_entry] <= 1'b0;
                        head_ff[job_entry]  <= '0;
                     end else begin
                        head_ff[job_entry] <= next_head;
                     end
                  end
               end
            end
            ST_READ: begin
               out_strobe_ff <= 1'b1;
               out_ff <= (msg_cnt_ff == 2'd0) ? reply_ff : msg_rsp;
            end
            ST_MSG: begin
               out_strobe_ff <= 1'b1;
               out_ff <= msg_rsp;
            end
            ST_REPLY: begin
               out_strobe_ff <= 1'b1;
               out_ff <= reply_ff;
            end
            default: ;
         endcase
      end
   end

   assign rsp_data   = out_ff;
   assign rsp_strobe = out_strobe_ff;
endmodule
